/* src/lgs_pkg.sv */
package lgs_pkg;

  localparam int ROW_BITS        = 64;
  localparam int POP_BITS        = 13;
  localparam int CFG_BITS        = 7;
  localparam int CFG_INDEX_BITS  = 1;
  localparam int INDEX_BITS      = 6;
  localparam int MODE_BITS       = 2;

  localparam int DEF_MAX_COLUMNS = 64;
  localparam int DEF_MAX_ROWS    = 64;

  localparam logic [CFG_BITS-1:0] GRID_WIDTH_RESET  = 7'd20;
  localparam logic [CFG_BITS-1:0] GRID_HEIGHT_RESET = 7'd20;

  localparam logic [CFG_INDEX_BITS-1:0] REG_GRID_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_GRID_HEIGHT = 1'b1;

  localparam logic [3:0] SURVIVE_LOW = 4'd2;
  localparam logic [3:0] BIRTH_COUNT = 4'd3;

  typedef enum logic [MODE_BITS-1:0] {
    MODE_LOAD = 2'd0,
    MODE_STEP = 2'd1,
    MODE_READ = 2'd2,
    MODE_NONE = 2'd3
  } mode_t;

  typedef struct packed {
    logic clear;
    logic valid;
    logic last;
  } merge_ctl_t;

endpackage

/* src/lgs_ram.sv */
module lgs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* src/lgs_lane.sv */
module lgs_lane (
  input  logic [2:0] up,
  input  logic [2:0] mid,
  input  logic [2:0] dn,
  output logic       alive_nxt
);

  logic [3:0] count;

  always_comb begin
    count = 4'(up[0]) + 4'(up[1]) + 4'(up[2]) + 4'(mid[0]) + 4'(mid[2])
          + 4'(dn[0]) + 4'(dn[1]) + 4'(dn[2]);
    if (mid[1]) begin
      alive_nxt = (count == lgs_pkg::SURVIVE_LOW) || (count == lgs_pkg::BIRTH_COUNT);
    end else begin
      alive_nxt = (count == lgs_pkg::BIRTH_COUNT);
    end
  end

endmodule

/* src/lgs_merge.sv */
module lgs_merge #(
  parameter int COLS = lgs_pkg::DEF_MAX_COLUMNS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  lgs_pkg::merge_ctl_t          ctl,
  input  logic [COLS-1:0]              row,
  output logic [lgs_pkg::POP_BITS-1:0] pop,
  output logic                         done
);

  localparam int NG = (COLS + 7) / 8;
  localparam int PW = NG * 8;
  localparam int CNTW = $clog2(COLS + 1);
  localparam int PB = lgs_pkg::POP_BITS;

  logic [PW-1:0]   row_pad;
  logic [3:0]      grp_cnt [NG];
  logic [3:0]      grp_r   [NG];
  logic [CNTW-1:0] row_sum;
  logic [CNTW-1:0] cnt_r;
  logic            v1_r, last1_r, v2_r, last2_r;
  logic [PB-1:0]   pop_r;
  logic            done_r;

  assign row_pad = PW'(row);

  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_cnt[g] = '0;
      for (int b = 0; b < 8; b++) begin
        grp_cnt[g] = grp_cnt[g] + 4'(row_pad[g*8 + b]);
      end
    end
    row_sum = '0;
    for (int g = 0; g < NG; g++) begin
      row_sum = row_sum + CNTW'(grp_r[g]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      last1_r <= 1'b0;
      v2_r    <= 1'b0;
      last2_r <= 1'b0;
      done_r  <= 1'b0;
      pop_r   <= '0;
    end else begin
      v1_r    <= ctl.valid && !ctl.clear;
      last1_r <= ctl.last;
      v2_r    <= v1_r && !ctl.clear;
      last2_r <= last1_r;
      done_r  <= v2_r && last2_r && !ctl.clear;
      if (ctl.clear) begin
        pop_r <= '0;
      end else if (v2_r) begin
        pop_r <= pop_r + PB'(cnt_r);
      end
    end
    grp_r <= grp_cnt;
    cnt_r <= row_sum;
  end

  assign pop  = pop_r;
  assign done = done_r;

endmodule

/* src/life_generation_step_top.sv */
// Bounded B3/S23 cellular grid, one row of cells per stored word.
// Input channel (in_valid / in_stall) carries one command item: in_mode selects
// load row, advance one generation, or read row; in_row_index and in_row_cells
// give the row and its cells. Every accepted item yields exactly one result item
// on the output channel (out_valid / out_stall): out_row_out for a read,
// out_population for a step, zeros otherwise.
// A step sweeps the row memory once, one full row per cycle through MAX_COLUMNS
// parallel cell lanes; each row passes the memory read, row window, lane output
// and two adder stages.
// Items are handled one at a time; in_stall drops in the same cycle that the result
// is offered. The next item is taken while the previous result still sits in the
// output register.
// cfg_we writes grid_width (index 0) or grid_height (index 1) from cfg_data;
// write only while the block is idle.
// Reset (rst_n low, synchronous) restores both sizes to 20 and starts a clearing
// pass that zeroes every row; in_stall stays high meanwhile.
// When the receiver stalls, the result holds in the output register and the
// block stops taking items once a second result is ready.
module life_generation_step_top #(
  parameter int MAX_COLUMNS = lgs_pkg::DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = lgs_pkg::DEF_MAX_ROWS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [lgs_pkg::MODE_BITS-1:0]       in_mode,
  input  logic [lgs_pkg::INDEX_BITS-1:0]      in_row_index,
  input  logic [lgs_pkg::ROW_BITS-1:0]        in_row_cells,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [lgs_pkg::ROW_BITS-1:0]        out_row_out,
  output logic [lgs_pkg::POP_BITS-1:0]        out_population,
  input  logic                                cfg_we,
  input  logic [lgs_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [lgs_pkg::CFG_BITS-1:0]        cfg_data
);

  localparam int COLS = MAX_COLUMNS;
  localparam int AW   = $clog2(MAX_ROWS);
  localparam int KW   = AW + 1;
  localparam int CW   = lgs_pkg::CFG_BITS;
  localparam int CMPW = (KW > CW) ? KW : CW;
  localparam int IDXW = lgs_pkg::INDEX_BITS;
  localparam int IW   = (AW > IDXW) ? AW : IDXW;
  localparam int RB   = lgs_pkg::ROW_BITS;
  localparam int PB   = lgs_pkg::POP_BITS;

  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_RD,
    ST_STEP,
    ST_FIN
  } state_t;

  state_t          state_r, state_nxt;
  logic [CW-1:0]   grid_width_r, grid_height_r;
  logic [AW-1:0]   clr_r, clr_nxt;
  logic            rd_ok_r, rd_ok_nxt;
  logic [RB-1:0]   res_row_r, res_row_nxt;
  logic [PB-1:0]   res_pop_r, res_pop_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [RB-1:0]   out_row_r, out_row_nxt;
  logic [PB-1:0]   out_pop_r, out_pop_nxt;

  logic [KW-1:0]   k_r;
  logic            iss_r;
  logic            vb_r;
  logic [KW-1:0]   kb_r;
  logic            vc_r, lastc_r;
  logic [AW-1:0]   yc_r;
  logic            vw_r, lastw_r;
  logic [AW-1:0]   yw_r;
  logic [COLS-1:0] up_r, cur_r, dn_r, nrow_r;

  logic [COLS-1:0] col_mask;
  logic [CMPW-1:0] h_used;
  logic [IW-1:0]   row_ext;
  logic [AW-1:0]   row_addr;
  logic [AW-1:0]   k_addr;
  logic [KW-1:0]   kb_m1;
  logic            accept;
  logic            step_go;
  logic [COLS+1:0] up_pad, cur_pad, dn_pad;
  logic [COLS-1:0] lane_out;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  logic [COLS-1:0] ram_wdata, ram_rdata;

  lgs_pkg::merge_ctl_t  merge_ctl;
  logic [PB-1:0]        merge_pop;
  logic                 merge_done;

  always_comb begin
    for (int x = 0; x < COLS; x++) begin
      col_mask[x] = (CW'(x) < grid_width_r);
    end
  end

  assign h_used   = (CMPW'(grid_height_r) > CMPW'(MAX_ROWS)) ? CMPW'(MAX_ROWS)
                                                             : CMPW'(grid_height_r);
  assign row_ext  = IW'(in_row_index);
  assign row_addr = row_ext[AW-1:0];
  assign k_addr   = (k_r == KW'(MAX_ROWS)) ? '0 : k_r[AW-1:0];
  assign kb_m1    = kb_r - KW'(1);
  assign accept   = in_valid && !in_stall;
  assign step_go  = accept && (in_mode == lgs_pkg::MODE_STEP);
  assign in_stall = (state_r != ST_IDLE);

  assign up_pad  = {1'b0, up_r, 1'b0};
  assign cur_pad = {1'b0, cur_r, 1'b0};
  assign dn_pad  = {1'b0, dn_r, 1'b0};

  for (genvar x = 0; x < COLS; x++) begin : g_lane
    lgs_lane u_lane (
      .up       (up_pad[x+2:x]),
      .mid      (cur_pad[x+2:x]),
      .dn       (dn_pad[x+2:x]),
      .alive_nxt(lane_out[x])
    );
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = yw_r;
    ram_wdata = nrow_r;
    ram_raddr = k_addr;
    case (state_r)
      ST_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
      end
      ST_IDLE: begin
        ram_raddr = row_addr;
        ram_waddr = row_addr;
        ram_wdata = in_row_cells[COLS-1:0] & col_mask;
        ram_we    = accept && (in_mode == lgs_pkg::MODE_LOAD)
                    && (CMPW'(in_row_index) < h_used);
      end
      ST_STEP: begin
        ram_we = vw_r;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  lgs_ram #(
    .WIDTH(COLS),
    .DEPTH(MAX_ROWS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign merge_ctl.clear = step_go;
  assign merge_ctl.valid = vw_r;
  assign merge_ctl.last  = lastw_r;

  lgs_merge #(
    .COLS(COLS)
  ) u_merge (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (merge_ctl),
    .row  (nrow_r),
    .pop  (merge_pop),
    .done (merge_done)
  );

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    rd_ok_nxt     = rd_ok_r;
    res_row_nxt   = res_row_r;
    res_pop_nxt   = res_pop_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_row_nxt   = out_row_r;
    out_pop_nxt   = out_pop_r;
    case (state_r)
      ST_CLR: begin
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(MAX_ROWS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          res_row_nxt = '0;
          res_pop_nxt = '0;
          rd_ok_nxt   = (CMPW'(in_row_index) < h_used);
          case (in_mode)
            lgs_pkg::MODE_READ: state_nxt = ST_RD;
            lgs_pkg::MODE_STEP: state_nxt = ST_STEP;
            default:            state_nxt = ST_FIN;
          endcase
        end
      end
      ST_RD: begin
        res_row_nxt = rd_ok_r ? RB'(ram_rdata & col_mask) : '0;
        state_nxt   = ST_FIN;
      end
      ST_STEP: begin
        if (merge_done) begin
          res_pop_nxt = merge_pop;
          state_nxt   = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_row_nxt   = res_row_r;
          out_pop_nxt   = res_pop_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_CLR;
      clr_r         <= '0;
      out_valid_r   <= 1'b0;
      grid_width_r  <= lgs_pkg::GRID_WIDTH_RESET;
      grid_height_r <= lgs_pkg::GRID_HEIGHT_RESET;
      iss_r         <= 1'b0;
      vb_r          <= 1'b0;
      vc_r          <= 1'b0;
      vw_r          <= 1'b0;
      lastc_r       <= 1'b0;
      lastw_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we && (cfg_index == lgs_pkg::REG_GRID_WIDTH)) begin
        grid_width_r <= cfg_data;
      end
      if (cfg_we && (cfg_index == lgs_pkg::REG_GRID_HEIGHT)) begin
        grid_height_r <= cfg_data;
      end

      if (step_go) begin
        iss_r <= 1'b1;
      end else if (iss_r && (k_r == KW'(MAX_ROWS))) begin
        iss_r <= 1'b0;
      end
      vb_r    <= iss_r && !step_go;
      vc_r    <= vb_r && (kb_r != '0) && !step_go;
      lastc_r <= (kb_r == KW'(MAX_ROWS));
      vw_r    <= vc_r && !step_go;
      lastw_r <= lastc_r;
    end

    rd_ok_r   <= rd_ok_nxt;
    res_row_r <= res_row_nxt;
    res_pop_r <= res_pop_nxt;
    out_row_r <= out_row_nxt;
    out_pop_r <= out_pop_nxt;

    if (step_go) begin
      k_r <= '0;
    end else if (iss_r) begin
      k_r <= k_r + KW'(1);
    end
    kb_r <= k_r;

    if (step_go) begin
      up_r  <= '0;
      cur_r <= '0;
      dn_r  <= '0;
    end else if (vb_r) begin
      up_r  <= cur_r;
      cur_r <= dn_r;
      dn_r  <= (CMPW'(kb_r) < h_used) ? (ram_rdata & col_mask) : '0;
    end
    yc_r <= kb_m1[AW-1:0];

    nrow_r <= (CMPW'(yc_r) < h_used) ? (lane_out & col_mask) : '0;
    yw_r   <= yc_r;
  end

  assign out_valid      = out_valid_r;
  assign out_row_out    = out_row_r;
  assign out_population = out_pop_r;

endmodule

/* src/lgs_checker.sv */
module lgs_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic [lgs_pkg::MODE_BITS-1:0]  in_mode,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [lgs_pkg::ROW_BITS-1:0]   out_row_out,
  input logic [lgs_pkg::POP_BITS-1:0]   out_population
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_row_out)
                               && $stable(out_population))
    else $error("stalled item changed or dropped");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("item offered right after reset");

  a_one_field: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_row_out == '0) || (out_population == '0))
    else $error("row and population both nonzero");

  a_step_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_mode == lgs_pkg::MODE_STEP) |=> in_stall)
    else $error("item taken during a generation step");

endmodule

bind life_generation_step_top lgs_checker u_lgs_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .in_mode       (in_mode),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_row_out   (out_row_out),
  .out_population(out_population)
);

/* tb/tb_life_generation_step_top.sv */
`timescale 1ns / 100ps

typedef struct packed {
  logic [lgs_pkg::ROW_BITS-1:0] row;
  logic [lgs_pkg::POP_BITS-1:0] pop;
} life_result_t;

class life_grid_tracker;
  logic [lgs_pkg::ROW_BITS-1:0] grid [lgs_pkg::DEF_MAX_ROWS];
  logic [lgs_pkg::CFG_BITS-1:0] width_reg;
  logic [lgs_pkg::CFG_BITS-1:0] height_reg;
  life_result_t                 pending_results [$];
  int                           mismatches;

  function new();
    foreach (grid[i]) grid[i] = '0;
    width_reg  = lgs_pkg::GRID_WIDTH_RESET;
    height_reg = lgs_pkg::GRID_HEIGHT_RESET;
    mismatches = 0;
  endfunction

  function void set_register(logic [lgs_pkg::CFG_INDEX_BITS-1:0] index,
                             logic [lgs_pkg::CFG_BITS-1:0] value);
    if (index == lgs_pkg::REG_GRID_WIDTH) begin
      width_reg = value;
    end else begin
      height_reg = value;
    end
  endfunction

  function int columns_in_use();
    return (width_reg > lgs_pkg::DEF_MAX_COLUMNS) ? lgs_pkg::DEF_MAX_COLUMNS
                                                  : int'(width_reg);
  endfunction

  function int rows_in_use();
    return (height_reg > lgs_pkg::DEF_MAX_ROWS) ? lgs_pkg::DEF_MAX_ROWS
                                                : int'(height_reg);
  endfunction

  function logic [lgs_pkg::ROW_BITS-1:0] column_mask();
    int w;
    w = columns_in_use();
    if (w >= lgs_pkg::ROW_BITS) return '1;
    return (lgs_pkg::ROW_BITS'(1) << w) - lgs_pkg::ROW_BITS'(1);
  endfunction

  function int bit_at(logic [lgs_pkg::ROW_BITS-1:0] r, int x, int w);
    if (x < 0 || x >= w) return 0;
    return int'(r[x]);
  endfunction

  function logic [lgs_pkg::POP_BITS-1:0] next_generation();
    logic [lgs_pkg::ROW_BITS-1:0] fresh [lgs_pkg::DEF_MAX_ROWS];
    logic [lgs_pkg::ROW_BITS-1:0] m;
    logic [lgs_pkg::ROW_BITS-1:0] up;
    logic [lgs_pkg::ROW_BITS-1:0] cur;
    logic [lgs_pkg::ROW_BITS-1:0] dn;
    int                           w;
    int                           h;
    int                           y;
    int                           x;
    int                           n;
    int                           live_total;
    logic                         lives;
    w = columns_in_use();
    h = rows_in_use();
    m = column_mask();
    live_total = 0;
    foreach (fresh[i]) fresh[i] = '0;
    for (y = 0; y < h; y++) begin
      cur = grid[y] & m;
      up  = (y > 0) ? (grid[y-1] & m) : '0;
      dn  = (y + 1 < h) ? (grid[y+1] & m) : '0;
      for (x = 0; x < w; x++) begin
        n = bit_at(up, x - 1, w) + bit_at(up, x, w) + bit_at(up, x + 1, w)
          + bit_at(cur, x - 1, w) + bit_at(cur, x + 1, w)
          + bit_at(dn, x - 1, w) + bit_at(dn, x, w) + bit_at(dn, x + 1, w);
        if (cur[x]) begin
          lives = (n == lgs_pkg::SURVIVE_LOW) || (n == lgs_pkg::BIRTH_COUNT);
        end else begin
          lives = (n == lgs_pkg::BIRTH_COUNT);
        end
        if (lives) begin
          fresh[y][x] = 1'b1;
          live_total++;
        end
      end
    end
    grid = fresh;
    return lgs_pkg::POP_BITS'(live_total);
  endfunction

  function void take_command(lgs_pkg::mode_t mode, logic [lgs_pkg::INDEX_BITS-1:0] index,
                             logic [lgs_pkg::ROW_BITS-1:0] cells_in);
    life_result_t res;
    res = '0;
    case (mode)
      lgs_pkg::MODE_LOAD: begin
        if (index < rows_in_use()) grid[index] = cells_in & column_mask();
      end
      lgs_pkg::MODE_STEP: begin
        res.pop = next_generation();
      end
      lgs_pkg::MODE_READ: begin
        if (index < rows_in_use()) res.row = grid[index] & column_mask();
      end
      default: begin
      end
    endcase
    pending_results.push_back(res);
  endfunction

  function bit waiting();
    return pending_results.size() != 0;
  endfunction

  task flag_mismatch(string msg);
    mismatches++;
    $display("mismatch: %s", msg);
  endtask

  task compare_result(logic [lgs_pkg::ROW_BITS-1:0] row, logic [lgs_pkg::POP_BITS-1:0] pop);
    life_result_t want;
    if (pending_results.size() == 0) begin
      flag_mismatch($sformatf("result with nothing pending: row %h population %0d", row, pop));
      return;
    end
    want = pending_results.pop_front();
    if (row !== want.row) begin
      flag_mismatch($sformatf("row_out %h, wanted %h", row, want.row));
    end
    if (pop !== want.pop) begin
      flag_mismatch($sformatf("population %0d, wanted %0d", pop, want.pop));
    end
  endtask
endclass

module tb_life_generation_step_top;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int TAIL_CYCLES = 100;

  typedef enum int {
    STALL_NONE,
    STALL_CHOPPY,
    STALL_LONG
  } stall_style_t;

  logic                               clk = 1'b0;
  logic                               rst_n;
  logic                               in_valid;
  logic                               in_stall;
  logic [lgs_pkg::MODE_BITS-1:0]      in_mode;
  logic [lgs_pkg::INDEX_BITS-1:0]     in_row_index;
  logic [lgs_pkg::ROW_BITS-1:0]       in_row_cells;
  logic                               out_valid;
  logic                               out_stall = 1'b0;
  logic [lgs_pkg::ROW_BITS-1:0]       out_row_out;
  logic [lgs_pkg::POP_BITS-1:0]       out_population;
  logic                               cfg_we;
  logic [lgs_pkg::CFG_INDEX_BITS-1:0] cfg_index;
  logic [lgs_pkg::CFG_BITS-1:0]       cfg_data;

  life_grid_tracker tracker = new();
  int               cycle_count = 0;
  stall_style_t     stall_style = STALL_NONE;
  int               stall_left = 0;
  int               burst_left = 0;
  bit               gaps_on = 1'b0;

  life_generation_step_top DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_mode        (in_mode),
    .in_row_index   (in_row_index),
    .in_row_cells   (in_row_cells),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_row_out    (out_row_out),
    .out_population (out_population),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
      case (stall_style)
        STALL_CHOPPY: begin
          if ($urandom_range(0, 99) < 30) stall_left = $urandom_range(1, 3);
        end
        STALL_LONG: begin
          if ($urandom_range(0, 99) < 6) stall_left = $urandom_range(5, 30);
        end
        default: begin
        end
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) tracker.compare_result(out_row_out, out_population);
  end

  task automatic pause_sender(int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic send_item(lgs_pkg::mode_t mode, logic [lgs_pkg::INDEX_BITS-1:0] index,
                           logic [lgs_pkg::ROW_BITS-1:0] cells_in);
    int gap;
    if (burst_left == 0) begin
      gap = gaps_on ? $urandom_range(0, 10) : 0;
      if (gap > 0) pause_sender(gap);
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_valid     <= 1'b1;
    in_mode      <= mode;
    in_row_index <= index;
    in_row_cells <= cells_in;
    do @(posedge clk); while (in_stall);
    tracker.take_command(mode, index, cells_in);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (tracker.waiting());
    burst_left = 0;
  endtask

  task automatic write_sizes(logic [lgs_pkg::CFG_BITS-1:0] w, logic [lgs_pkg::CFG_BITS-1:0] h);
    cfg_we    <= 1'b1;
    cfg_index <= lgs_pkg::REG_GRID_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    cfg_index <= lgs_pkg::REG_GRID_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.set_register(lgs_pkg::REG_GRID_WIDTH, w);
    tracker.set_register(lgs_pkg::REG_GRID_HEIGHT, h);
  endtask

  function automatic logic [lgs_pkg::ROW_BITS-1:0] random_row();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return {$urandom, $urandom};
      3: return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
      4: return {$urandom, $urandom} | {$urandom, $urandom};
      default: return lgs_pkg::ROW_BITS'(7) << $urandom_range(0, lgs_pkg::ROW_BITS - 1);
    endcase
  endfunction

  function automatic logic [lgs_pkg::INDEX_BITS-1:0] random_index();
    int h;
    h = tracker.rows_in_use();
    if (h > 0 && $urandom_range(0, 4) != 0) begin
      return lgs_pkg::INDEX_BITS'($urandom_range(0, h - 1));
    end
    return lgs_pkg::INDEX_BITS'($urandom_range(0, lgs_pkg::DEF_MAX_ROWS - 1));
  endfunction

  task automatic run_phase(logic [lgs_pkg::CFG_BITS-1:0] w, logic [lgs_pkg::CFG_BITS-1:0] h,
                           int count);
    int sent;
    int pick;
    int rows;
    int y;
    drain();
    write_sizes(w, h);
    stall_style = stall_style_t'($urandom_range(0, 2));
    gaps_on = 1'($urandom_range(0, 1));
    sent = 0;
    rows = tracker.rows_in_use();
    if ($urandom_range(0, 3) != 0) begin
      for (y = 0; y < rows && sent < count; y++) begin
        send_item(lgs_pkg::MODE_LOAD, lgs_pkg::INDEX_BITS'(y), random_row());
        sent++;
      end
    end
    while (sent < count) begin
      pick = $urandom_range(0, 99);
      if (pick >= 98) begin
        drain();
      end else begin
        if (pick < 40) begin
          send_item(lgs_pkg::MODE_LOAD, random_index(), random_row());
        end else if (pick < 70) begin
          send_item(lgs_pkg::MODE_READ, random_index(), random_row());
        end else if (pick < 94) begin
          send_item(lgs_pkg::MODE_STEP, random_index(), random_row());
        end else begin
          send_item(lgs_pkg::MODE_NONE, random_index(), random_row());
        end
        sent++;
      end
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_mode      = lgs_pkg::MODE_LOAD;
    in_row_index = '0;
    in_row_cells = '0;
    cfg_we       = 1'b0;
    cfg_index    = lgs_pkg::REG_GRID_WIDTH;
    cfg_data     = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    send_item(lgs_pkg::MODE_READ, 6'd0, '0);
    send_item(lgs_pkg::MODE_LOAD, 6'd0, '1);
    send_item(lgs_pkg::MODE_READ, 6'd0, '1);
    send_item(lgs_pkg::MODE_LOAD, 6'd63, '1);
    send_item(lgs_pkg::MODE_READ, 6'd63, '1);
    send_item(lgs_pkg::MODE_NONE, 6'd63, '1);
    send_item(lgs_pkg::MODE_LOAD, 6'd5, 64'h38);
    send_item(lgs_pkg::MODE_STEP, 6'd0, '0);
    send_item(lgs_pkg::MODE_READ, 6'd4, '0);
    send_item(lgs_pkg::MODE_READ, 6'd5, '0);
    send_item(lgs_pkg::MODE_READ, 6'd6, '0);
    send_item(lgs_pkg::MODE_STEP, 6'd0, '1);
    send_item(lgs_pkg::MODE_READ, 6'd5, '0);
    send_item(lgs_pkg::MODE_LOAD, 6'd19, '1);
    send_item(lgs_pkg::MODE_LOAD, 6'd18, '0);
    send_item(lgs_pkg::MODE_STEP, 6'd0, '0);
    send_item(lgs_pkg::MODE_READ, 6'd18, '0);
    send_item(lgs_pkg::MODE_READ, 6'd19, '0);
    send_item(lgs_pkg::MODE_READ, 6'd0, '0);
    send_item(lgs_pkg::MODE_READ, 6'd1, '0);

    run_phase(7'd64, 7'd64, 160);
    run_phase(7'd1, 7'd1, 80);
    run_phase(7'd3, 7'd3, 100);
    run_phase(7'd64, 7'd1, 100);
    run_phase(7'd1, 7'd64, 120);
    run_phase(7'd64, 7'd3, 100);
    run_phase(7'd3, 7'd64, 120);
    run_phase(7'd0, 7'd8, 60);
    run_phase(7'd8, 7'd0, 60);
    run_phase(7'd127, 7'd127, 140);
    run_phase(7'd100, 7'd2, 80);
    repeat (8) begin
      run_phase(lgs_pkg::CFG_BITS'($urandom_range(1, 64)),
                lgs_pkg::CFG_BITS'($urandom_range(1, 64)), 100);
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0 && !tracker.waiting()) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
